// File: rtl/core/swm_pkg.sv
// Shared types and constants for the sliding window median block.
`timescale 1ns / 1ps

package swm_pkg;

   localparam int WS_BITS = 7;
   localparam int SUM_BITS = 48;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
   localparam logic [WS_BITS-1:0] WS_RESET = 7'd1;

   // register index as seen on csr_paddr[2]
   localparam logic CSR_IDX_WINDOW_SIZE = 1'b0;

   typedef struct packed {
      logic load;      // latch sample, window size and trimmed count/pointer
      logic rem_init;  // read oldest sample from history, arm removal scan
      logic rem_step;  // one step of the removal scan
      logic ins_init;  // fix count after removal, arm insertion scan
      logic ins_step;  // one step of the insertion scan
      logic med_rd;    // read the median slot
      logic emit;      // load result register and, when the window is full, update the sum
   } swm_cmd_type;

   typedef struct packed {
      logic win_full;  // count equals window size
      logic rem_done;  // removal scan has passed the last entry
      logic ins_done;  // insertion slot found this cycle
      logic out_free;  // result register can take a word
   } swm_status_type;

endpackage

// File: rtl/core/swm_ctrl.sv
// Sequencer for the sliding window median: issues datapath commands per word.
`timescale 1ns / 1ps

module swm_ctrl
   import swm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  swm_status_type st,
   output swm_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_START    = 3'd1;
   localparam logic [2:0] S_REM      = 3'd2;
   localparam logic [2:0] S_INS_INIT = 3'd3;
   localparam logic [2:0] S_INS      = 3'd4;
   localparam logic [2:0] S_MED      = 3'd5;
   localparam logic [2:0] S_OUT      = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            if (st.win_full) begin
               cmd.rem_init = 1'b1;
               state_in     = S_REM;
            end else begin
               cmd.ins_init = 1'b1;
               state_in     = S_INS;
            end
         end
         S_REM: begin
            if (st.rem_done) begin
               state_in = S_INS_INIT;
            end else begin
               cmd.rem_step = 1'b1;
            end
         end
         S_INS_INIT: begin
            cmd.ins_init = 1'b1;
            state_in     = S_INS;
         end
         S_INS: begin
            cmd.ins_step = 1'b1;
            if (st.ins_done) begin
               state_in = S_MED;
            end
         end
         S_MED: begin
            cmd.med_rd = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/swm_dpath.sv
// Datapath for the sliding window median: history and sorted memories, scans, sum.
`timescale 1ns / 1ps

module swm_dpath
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swm_cmd_type            cmd,
   output swm_status_type         st,
   input  logic [WS_BITS-1:0]     win_size,
   input  logic                   cfg_clear,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [SAMPLE_BITS-1:0] rsp_median,
   output logic                   rsp_full,
   output logic [SUM_BITS-1:0]    rsp_sum
);

   localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int SUM_WIDE = SUM_BITS + 1;

   logic [SAMPLE_BITS-1:0] sort_mem [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];

   logic                   sort_re, sort_we, hist_re, hist_we;
   logic [IW-1:0]          sort_ra, sort_wa;
   logic [SAMPLE_BITS-1:0] sort_wd;
   logic [SAMPLE_BITS-1:0] sort_q_ff, hist_q_ff;

   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [CW-1:0]          k_ff, k_in;
   logic [CW-1:0]          n_ff, n_in;
   logic [CW-1:0]          fill_ff, fill_in;
   logic [IW-1:0]          ptr_ff, ptr_in;
   logic [CW-1:0]          ra_ff, ra_in;
   logic [IW-1:0]          pa_ff, pa_in;
   logic                   pv_ff, pv_in;
   logic                   found_ff, found_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_med_ff, rsp_med_in;
   logic                   rsp_full_ff, rsp_full_in;
   logic [SUM_BITS-1:0]    rsp_sum_ff, rsp_sum_in;

   logic [CW-1:0]          k_eff;
   logic [CW-1:0]          mid;
   logic [CW-1:0]          ptr_next;
   logic [CW-1:0]          n_trim;
   logic                   ins_stop;
   logic [SUM_WIDE-1:0]    sum_wide;

   // window size zero means one, sizes above the array depth saturate
   always_comb begin
      if (win_size == '0) begin
         k_eff = CW'(1);
      end else if (32'(win_size) > 32'(MAX_WINDOW)) begin
         k_eff = CW'(MAX_WINDOW);
      end else begin
         k_eff = CW'(win_size);
      end
   end

   assign mid      = (k_ff - 1'b1) >> 1;
   assign ptr_next = CW'(ptr_ff) + 1'b1;
   assign n_trim   = found_ff ? (n_ff - 1'b1) : n_ff;
   assign ins_stop = pv_ff ? !(sort_q_ff > sample_ff) : (ra_ff == '0);
   assign sum_wide = {1'b0, sum_ff} + SUM_WIDE'(sort_q_ff);

   assign st.win_full = (n_ff == k_ff);
   assign st.rem_done = (ra_ff == n_ff) && !pv_ff;
   assign st.ins_done = ins_stop;
   assign st.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sample_in    = sample_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      ra_in        = ra_ff;
      pa_in        = pa_ff;
      pv_in        = pv_ff;
      found_in     = found_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_med_in   = rsp_med_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_sum_in   = rsp_sum_ff;
      sort_re      = 1'b0;
      sort_ra      = '0;
      sort_we      = 1'b0;
      sort_wa      = '0;
      sort_wd      = '0;
      hist_re      = 1'b0;
      hist_we      = 1'b0;

      if (cfg_clear) begin
         fill_in = '0;
         ptr_in  = '0;
      end

      if (cmd.load) begin
         sample_in = req_sample;
         k_in      = k_eff;
         n_in      = (fill_ff > k_eff) ? k_eff : fill_ff;
         ptr_in    = (CW'(ptr_ff) >= k_eff) ? '0 : ptr_ff;
         found_in  = 1'b0;
      end

      if (cmd.rem_init) begin
         hist_re  = 1'b1;
         ra_in    = '0;
         pv_in    = 1'b0;
         found_in = 1'b0;
      end

      // upward scan: drop the first match, pull later entries down one slot
      if (cmd.rem_step) begin
         if (ra_ff < n_ff) begin
            sort_re = 1'b1;
            sort_ra = ra_ff[IW-1:0];
            pa_in   = ra_ff[IW-1:0];
            pv_in   = 1'b1;
            ra_in   = ra_ff + 1'b1;
         end else begin
            pv_in = 1'b0;
         end
         if (pv_ff) begin
            if (found_ff) begin
               sort_we = 1'b1;
               sort_wa = pa_ff - 1'b1;
               sort_wd = sort_q_ff;
            end else if (sort_q_ff == hist_q_ff) begin
               found_in = 1'b1;
            end
         end
      end

      if (cmd.ins_init) begin
         n_in  = n_trim;
         ra_in = n_trim;
         pv_in = 1'b0;
      end

      // downward scan: push larger entries up one slot until the gap fits
      if (cmd.ins_step) begin
         if (pv_ff) begin
            sort_we = 1'b1;
            sort_wa = pa_ff + 1'b1;
            sort_wd = ins_stop ? sample_ff : sort_q_ff;
         end else if (ins_stop) begin
            sort_we = 1'b1;
            sort_wa = '0;
            sort_wd = sample_ff;
         end
         if (!ins_stop && (ra_ff != '0)) begin
            sort_re = 1'b1;
            sort_ra = IW'(ra_ff - 1'b1);
            pa_in   = IW'(ra_ff - 1'b1);
            pv_in   = 1'b1;
            ra_in   = ra_ff - 1'b1;
         end else begin
            pv_in = 1'b0;
         end
         if (ins_stop) begin
            n_in    = n_ff + 1'b1;
            fill_in = n_ff + 1'b1;
            hist_we = 1'b1;
            ptr_in  = (ptr_next >= k_ff) ? '0 : ptr_next[IW-1:0];
         end
      end

      if (cmd.med_rd) begin
         sort_re = 1'b1;
         sort_ra = mid[IW-1:0];
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_full_in  = st.win_full;
         if (st.win_full) begin
            rsp_med_in = sort_q_ff;
            sum_in     = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
            rsp_sum_in = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
         end else begin
            rsp_med_in = '0;
            rsp_sum_in = sum_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sort_we) begin
         sort_mem[sort_wa] <= sort_wd;
      end
      if (sort_re) begin
         sort_q_ff <= sort_mem[sort_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[ptr_ff] <= sample_ff;
      end
      if (hist_re) begin
         hist_q_ff <= hist_mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         ptr_ff       <= '0;
         sum_ff       <= '0;
         pv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         pv_ff        <= pv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      ra_ff       <= ra_in;
      pa_ff       <= pa_in;
      rsp_med_ff  <= rsp_med_in;
      rsp_full_ff <= rsp_full_in;
      rsp_sum_ff  <= rsp_sum_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_med_ff;
   assign rsp_full   = rsp_full_ff;
   assign rsp_sum    = rsp_sum_ff;

endmodule

// File: rtl/core/sliding_window_median.sv
// Top level of the sliding window median filter: CSR port, sequencer and datapath.
//
//  channel | direction | handshake            | contents
//  --------+-----------+----------------------+---------------------------------------
//  req     | in        | req_tvalid/tready    | tdata: sample
//  rsp     | out       | rsp_tvalid/tready    | tdata: median, median_sum; tuser: full
//  csr     | in        | APB, pready tied high| reg 0 window_size (7 bits, reset 1)
//
// Per word: the sequencer scans the sorted memory through its single read port,
//   once to drop the oldest sample when the window is full and once to insert
//   the new one, and then waits while the result register is still held by
//   rsp_tready low.
// Reset clears the window count, ring pointer, median sum and result valid flag.
// A new word is taken while an earlier result still waits in the result
//   register; a stalled rsp side holds the sequencer in its last state only.
// A write to window_size empties the window but keeps the median sum.
`timescale 1ns / 1ps

module sliding_window_median
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // tdata: sample [SAMPLE_BITS-1:0], zero padding above
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tdata: median [SAMPLE_BITS-1:0], median_sum [SAMPLE_BITS+47:SAMPLE_BITS], zero pad
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [((SAMPLE_BITS + SUM_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   // tuser: window_full
   output logic                     rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int OUT_W = ((SAMPLE_BITS + SUM_BITS + 7) / 8) * 8;

   swm_cmd_type            cmd;
   swm_status_type         st;
   logic [WS_BITS-1:0]     win_size_ff, win_size_in;
   logic                   cfg_wr;
   logic [SAMPLE_BITS-1:0] rsp_median;
   logic [SUM_BITS-1:0]    rsp_sum;

   // register writes land on the access phase; word address from paddr[2]
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == CSR_IDX_WINDOW_SIZE);
   assign win_size_in = cfg_wr ? csr_pwdata[WS_BITS-1:0] : win_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= WS_RESET;
      end else begin
         win_size_ff <= win_size_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_WINDOW_SIZE) begin
         csr_prdata = CSR_DATA_BITS'(win_size_ff);
      end
   end

   swm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .st        (st),
      .cmd       (cmd)
   );

   swm_dpath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .win_size   (win_size_ff),
      .cfg_clear  (cfg_wr),
      .req_sample (req_tdata[SAMPLE_BITS-1:0]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_median (rsp_median),
      .rsp_full   (rsp_tuser),
      .rsp_sum    (rsp_sum)
   );

   // median in the low bits, saturating sum above it
   assign rsp_tdata = OUT_W'({rsp_sum, rsp_median});

endmodule
